@@ design/bfns_pkg.sv @@
// bitmap_find_next_set package: request and result types, request codes and field widths
// no dependencies
package bfns_pkg;

    localparam int TYPE_W = 2;
    localparam int SEL_W  = 4;
    localparam int POS_W  = 10;
    localparam int IDX_W  = 11;
    // bit index of a word start, wide enough for limit plus one word
    localparam int BASE_W = 12;

    localparam logic [TYPE_W-1:0] REQ_SET   = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_CLEAR = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_SCAN  = 2'd2;

    typedef struct packed {
        logic [TYPE_W-1:0] req_type;
        logic [SEL_W-1:0]  set_select;
        logic [POS_W-1:0]  position;
    } t_bfns_req;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] found_index;
    } t_bfns_res;

endpackage

@@ design/bfns_ram.sv @@
// bitmap_find_next_set word store: generic single-clock ram, one write and one registered read
// no dependencies
module bfns_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256,
    parameter int ADDR_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/bfns_tzc.sv @@
// bitmap_find_next_set trailing zero counter over one word
// no dependencies; result is meaningful only for a nonzero word
module bfns_tzc #(
    parameter int WIDTH = 64
) (
    input  logic [WIDTH-1:0]         i_word,
    output logic [$clog2(WIDTH)-1:0] o_count
);

    localparam int CNT_W = $clog2(WIDTH);
    localparam int PAD_W = 1 << CNT_W;

    always_comb begin
        logic [PAD_W-1:0] v;
        logic [CNT_W-1:0] cnt;
        v   = PAD_W'(i_word);
        cnt = '0;
        // halve the window each level: low half empty means skip it
        for (int l = CNT_W - 1; l >= 0; l--) begin
            if ((v & ((PAD_W'(1) << (1 << l)) - PAD_W'(1))) == '0) begin
                cnt[l] = 1'b1;
                v      = v >> (1 << l);
            end
        end
        o_count = cnt;
    end

endmodule

@@ design/bitmap_find_next_set.sv @@
// bitmap_find_next_set top level: bank of membership bitmaps with set, clear and next-set scan
// depends on bfns_pkg, bfns_ram, bfns_tzc
//
// channel   direction  handshake                  payload
// -------   ---------  -------------------------  ----------------------
// in        input      i_in_valid / o_in_stall    i_in  (t_bfns_req)
// out       output     o_out_valid / i_out_stall  o_out (t_bfns_res)
// cfg       input      i_cfg_wr_en                i_cfg_wr_data (limit)
//
// set and clear pass through locate, read and modify-write (S_LOC0, S_LOC1, S_RD, S_RMW)
// a scan locates and reads the start word in the same way, then examines 1 up to MAX_ENTRIES/WORD_BITS words,
// bounded by the single ram read port that delivers one word per cycle
// the spare code and an out-of-range set or clear are done in their accepting cycle;
// a scan that answers none from the start goes from the accept straight to the push
// after reset a clearing pass writes zero to all NUM_SETS*ceil(MAX_ENTRIES/WORD_BITS) words,
// one per cycle, with o_in_stall high; the limit register is writable during it
// a scan result waits in the output register under i_out_stall; the next request is taken meanwhile
module bitmap_find_next_set #(
    parameter int NUM_SETS    = 16,
    parameter int MAX_ENTRIES = 1024,
    parameter int WORD_BITS   = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [bfns_pkg::IDX_W-1:0]      i_cfg_wr_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  bfns_pkg::t_bfns_req             i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output bfns_pkg::t_bfns_res             o_out
);

    import bfns_pkg::*;

    // store geometry
    localparam int WORDS_PER_SET = (MAX_ENTRIES + WORD_BITS - 1) / WORD_BITS;
    localparam int DEPTH         = NUM_SETS * WORDS_PER_SET;
    localparam int ADDR_W        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int AX_W          = ADDR_W + 8;
    localparam int OFF_W         = $clog2(WORD_BITS);
    // word counter reaches one past the last word below the largest limit
    localparam int WI_W          = $clog2(2048 / WORD_BITS + 2);

    // divide by word size: multiply by floor reciprocal, then one correction step
    localparam int SH            = 16;
    localparam int PROD_W        = POS_W + SH;
    localparam int RECIP         = (1 << SH) / WORD_BITS;

    // limits above the bitmap size act as the bitmap size
    localparam int CLAMP         = (MAX_ENTRIES < 2047) ? MAX_ENTRIES : 2047;

    localparam logic [PROD_W-1:0] RECIP_V   = PROD_W'(RECIP);
    localparam logic [IDX_W-1:0]  CLAMP_V   = IDX_W'(CLAMP);
    localparam logic [16:0]       MAX_V     = 17'(MAX_ENTRIES);
    localparam logic [6:0]        NSETS_V   = 7'(NUM_SETS);
    localparam logic [IDX_W-1:0]  NONE_IDX  = IDX_W'(MAX_ENTRIES % 2048);
    localparam logic [BASE_W-1:0] WB_V      = BASE_W'(WORD_BITS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_LOC0,
        S_LOC1,
        S_RD,
        S_RMW,
        S_SCAN,
        S_PUSH
    } t_state;

    // control
    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_clr, n_clr;
    logic [IDX_W-1:0]    r_limit, n_limit;
    logic                r_out_valid, n_out_valid;

    // request and walk registers
    logic [TYPE_W-1:0]   r_type, n_type;
    logic [SEL_W-1:0]    r_sel, n_sel;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [WI_W-1:0]     r_wi, n_wi;
    logic [BASE_W-1:0]   r_base, n_base;
    logic [OFF_W-1:0]    r_off, n_off;
    logic                r_first, n_first;
    logic                r_found, n_found;
    logic [IDX_W-1:0]    r_idx, n_idx;
    t_bfns_res           r_out, n_out;

    // datapath
    logic [PROD_W-1:0]   w_prod;
    logic [BASE_W-1:0]   w_wbase;
    logic [BASE_W-1:0]   w_rem;
    logic [BASE_W-1:0]   w_next_base;
    logic [WI_W-1:0]     w_rd_wi;
    logic [AX_W-1:0]     w_addr_x;
    logic [ADDR_W-1:0]   w_addr;
    logic [WORD_BITS-1:0] w_rdata;
    logic [WORD_BITS-1:0] w_bit;
    logic [WORD_BITS-1:0] w_scan_word;
    logic [OFF_W-1:0]    w_tz;
    logic                w_we;
    logic [ADDR_W-1:0]   w_waddr;
    logic [WORD_BITS-1:0] w_wdata;
    logic                w_accept;
    logic                w_sel_bad;
    logic                w_out_free;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_sel_bad  = {3'b000, i_in.set_select} >= NSETS_V;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // quotient estimate, equal to the word index or one below it
    assign w_prod      = PROD_W'(r_pos) * RECIP_V;
    assign w_wbase     = BASE_W'(r_wi) * WB_V;
    assign w_rem       = BASE_W'(r_pos) - w_wbase;
    assign w_next_base = r_base + WB_V;

    // while scanning, the read runs one word ahead of the word being examined
    assign w_rd_wi  = (r_state == S_SCAN) ? (r_wi + WI_W'(1)) : r_wi;
    assign w_addr_x = AX_W'(r_sel) * AX_W'(WORDS_PER_SET) + AX_W'(w_rd_wi);
    assign w_addr   = w_addr_x[ADDR_W-1:0];

    assign w_bit       = WORD_BITS'(1) << r_off;
    // first word only counts from the start bit upward
    assign w_scan_word = r_first ? (w_rdata & ({WORD_BITS{1'b1}} << r_off)) : w_rdata;

    bfns_ram #(
        .WIDTH  (WORD_BITS),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_addr),
        .o_rdata (w_rdata)
    );

    bfns_tzc #(
        .WIDTH (WORD_BITS)
    ) u_tzc (
        .i_word  (w_scan_word),
        .o_count (w_tz)
    );

    // ram write: clearing pass or read-modify-write of one bit
    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_addr;
        w_wdata = w_rdata;
        unique case (r_state)
            S_CLR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '0;
            end
            S_RMW: begin
                w_we    = 1'b1;
                w_wdata = (r_type == REQ_SET) ? (w_rdata | w_bit) : (w_rdata & ~w_bit);
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_limit     = r_limit;
        n_out_valid = r_out_valid;
        n_type      = r_type;
        n_sel       = r_sel;
        n_pos       = r_pos;
        n_wi        = r_wi;
        n_base      = r_base;
        n_off       = r_off;
        n_first     = r_first;
        n_found     = r_found;
        n_idx       = r_idx;
        n_out       = r_out;

        if (i_cfg_wr_en) begin
            n_limit = (i_cfg_wr_data > CLAMP_V) ? CLAMP_V : i_cfg_wr_data;
        end

        // output register drains independently of the sequencer
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLR: begin
                n_clr = r_clr + ADDR_W'(1);
                if (r_clr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_type = i_in.req_type;
                    n_sel  = i_in.set_select;
                    n_pos  = i_in.position;
                    if (i_in.req_type == REQ_SCAN) begin
                        // bad bitmap, or start at or past the limit: answer none
                        if (w_sel_bad || ({1'b0, i_in.position} >= r_limit)) begin
                            n_found = 1'b0;
                            n_idx   = NONE_IDX;
                            n_state = S_PUSH;
                        end else begin
                            n_state = S_LOC0;
                        end
                    end else if ((i_in.req_type == REQ_SET || i_in.req_type == REQ_CLEAR)
                                 && !w_sel_bad
                                 && ({7'd0, i_in.position} < MAX_V)) begin
                        n_state = S_LOC0;
                    end
                end
            end
            S_LOC0: begin
                n_wi    = WI_W'(w_prod[PROD_W-1:SH]);
                n_state = S_LOC1;
            end
            S_LOC1: begin
                n_first = 1'b1;
                if (w_rem >= WB_V) begin
                    n_wi   = r_wi + WI_W'(1);
                    n_base = w_wbase + WB_V;
                    n_off  = OFF_W'(w_rem - WB_V);
                end else begin
                    n_base = w_wbase;
                    n_off  = OFF_W'(w_rem);
                end
                n_state = S_RD;
            end
            S_RD: begin
                n_state = (r_type == REQ_SCAN) ? S_SCAN : S_RMW;
            end
            S_RMW: begin
                n_state = S_IDLE;
            end
            S_SCAN: begin
                if (w_scan_word != '0) begin
                    n_found = 1'b1;
                    n_idx   = IDX_W'(r_base + BASE_W'(w_tz));
                    n_state = S_PUSH;
                end else if (w_next_base >= BASE_W'(r_limit)) begin
                    // passed the word holding limit-1
                    n_found = 1'b0;
                    n_idx   = NONE_IDX;
                    n_state = S_PUSH;
                end else begin
                    n_wi    = r_wi + WI_W'(1);
                    n_base  = w_next_base;
                    n_first = 1'b0;
                end
            end
            S_PUSH: begin
                if (w_out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.found       = r_found;
                    n_out.found_index = r_idx;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_limit     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_limit     <= n_limit;
            r_out_valid <= n_out_valid;
            r_type      <= n_type;
            r_sel       <= n_sel;
            r_pos       <= n_pos;
            r_wi        <= n_wi;
            r_base      <= n_base;
            r_off       <= n_off;
            r_first     <= n_first;
            r_found     <= n_found;
            r_idx       <= n_idx;
            r_out       <= n_out;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

@@ tb/bfns_checker.sv @@
// bitmap_find_next_set checker: watches the request, result and limit channels,
// predicts every scan answer and compares it; depends on bfns_pkg
module bfns_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [bfns_pkg::IDX_W-1:0] i_cfg_wr_data,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  bfns_pkg::t_bfns_req        i_in,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  bfns_pkg::t_bfns_res        i_out,
    output int                         o_fail_count,
    output int                         o_pending
);
    import bfns_pkg::*;

    localparam int NUM_SETS      = 16;
    localparam int MAX_ENTRIES   = 1024;
    localparam int WORD_BITS     = 64;
    localparam int WORDS_PER_SET = MAX_ENTRIES / WORD_BITS;
    localparam logic [IDX_W-1:0] NONE_INDEX = IDX_W'(MAX_ENTRIES);

    logic [WORD_BITS-1:0] bitmap_q [NUM_SETS][WORDS_PER_SET];
    logic [IDX_W-1:0]     active_limit;
    t_bfns_res            scan_answers [$];
    int                   fail_count = 0;

    assign o_fail_count = fail_count;

    // lowest set bit at or after start, out to the word that holds limit-1
    // (tail bits of that word past the limit are not masked)
    function automatic t_bfns_res next_set_from(input logic [SEL_W-1:0] sel,
                                                input logic [POS_W-1:0] start);
        t_bfns_res            res;
        int                   lim;
        int                   last_word;
        int                   first_word;
        logic [WORD_BITS-1:0] word;
        res.found       = 1'b0;
        res.found_index = NONE_INDEX;
        lim = (int'(active_limit) > MAX_ENTRIES) ? MAX_ENTRIES : int'(active_limit);
        if (int'(start) >= lim) begin
            return res;
        end
        first_word = int'(start) / WORD_BITS;
        last_word  = (lim - 1) / WORD_BITS;
        for (int wi = first_word; wi <= last_word; wi++) begin
            word = bitmap_q[sel][wi];
            if (wi == first_word) begin
                word = word & ({WORD_BITS{1'b1}} << (int'(start) % WORD_BITS));
            end
            for (int b = 0; b < WORD_BITS; b++) begin
                if (word[b]) begin
                    res.found       = 1'b1;
                    res.found_index = IDX_W'(wi * WORD_BITS + b);
                    return res;
                end
            end
        end
        return res;
    endfunction

    task automatic log_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%s", msg);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_bfns_res want;
        int        wi;
        if (!i_rst_n) begin
            foreach (bitmap_q[s, w]) bitmap_q[s][w] = '0;
            active_limit = '0;
            scan_answers.delete();
        end else begin
            if (i_cfg_wr_en) begin
                active_limit = i_cfg_wr_data;
            end
            // a result accepted now always belongs to an earlier scan
            if (i_out_valid && !i_out_stall) begin
                if (scan_answers.size() == 0) begin
                    log_failure($sformatf("unexpected result found=%0d index=%0d",
                                          i_out.found, i_out.found_index));
                end else begin
                    want = scan_answers.pop_front();
                    if (i_out.found !== want.found ||
                        i_out.found_index !== want.found_index) begin
                        log_failure($sformatf(
                            "result mismatch: expected found=%0d index=%0d, got found=%0d index=%0d",
                            want.found, want.found_index, i_out.found, i_out.found_index));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                wi = int'(i_in.position) / WORD_BITS;
                case (i_in.req_type)
                    REQ_SET: begin
                        bitmap_q[i_in.set_select][wi][int'(i_in.position) % WORD_BITS] = 1'b1;
                    end
                    REQ_CLEAR: begin
                        bitmap_q[i_in.set_select][wi][int'(i_in.position) % WORD_BITS] = 1'b0;
                    end
                    REQ_SCAN: begin
                        scan_answers.push_back(next_set_from(i_in.set_select, i_in.position));
                    end
                    default: ;
                endcase
            end
        end
        o_pending <= scan_answers.size();
    end

endmodule

@@ tb/tb.sv @@
// testbench top for bitmap_find_next_set: clock, reset, request and limit stimulus, verdict
// depends on bfns_pkg, bitmap_find_next_set and bfns_checker
module tb;
    import bfns_pkg::*;

    // the spare request code, which the block must ignore
    localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;

    localparam int unsigned CYCLE_LIMIT = 300000;
    // time for a set or clear still in flight to finish
    localparam int SETTLE_CYCLES   = 8;
    // time for a full scan, which examines 16 words at most
    localparam int END_CYCLES      = 40;
    localparam int ITEMS_PER_PHASE = 66;
    localparam int WORD_SPAN       = 64;
    localparam int MAX_ENTRIES     = 1024;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [IDX_W-1:0] cfg_wr_data = '0;
    logic             in_valid    = 1'b0;
    logic             in_stall;
    t_bfns_req        in_req      = '0;
    logic             out_valid;
    logic             out_stall   = 1'b0;
    t_bfns_res        out_res;

    int          fail_count;
    int          n_pending;
    int unsigned cycle_cnt      = 0;
    // idle rates in percent, changed only between phases
    int          send_gap_pct   = 0;
    int          recv_stall_pct = 0;
    // limit as the block applies it, for aiming positions below it
    int          limit_eff      = 0;

    bitmap_find_next_set u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_in          (in_req),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out         (out_res)
    );

    bfns_checker u_chk (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in          (in_req),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out         (out_res),
        .o_fail_count  (fail_count),
        .o_pending     (n_pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // result side: stall drawn fresh each cycle, independent of valid
    always @(posedge clk) begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // hung run guard
    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    // one request: optional random gap first, then hold valid and payload
    // until the block takes it; valid stays high afterwards so back-to-back
    // requests never lower and raise it in the same step
    task automatic send_req(input logic [TYPE_W-1:0] kind,
                            input logic [SEL_W-1:0]  sel,
                            input logic [POS_W-1:0]  pos);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= '{req_type: kind, set_select: sel, position: pos};
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
    endtask

    // idle the request side, wait for every scan answer, then let a trailing
    // set or clear finish before the limit may change
    task automatic drain(input int extra);
        in_valid <= 1'b0;
        @(posedge clk);
        while (n_pending != 0) begin
            @(posedge clk);
        end
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_limit(input logic [IDX_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        limit_eff = (int'(value) > MAX_ENTRIES) ? MAX_ENTRIES : int'(value);
    endtask

    initial begin : stimulus
        logic [IDX_W-1:0]  limit_plan [6];
        logic [TYPE_W-1:0] kind;
        logic [SEL_W-1:0]  sel;
        logic [POS_W-1:0]  pos;
        int                sent;
        int                roll;

        // limits for the random phases: full, one word, oversized, single entity, two random
        limit_plan = '{11'd1024, 11'd64, 11'd2047, 11'd1,
                       IDX_W'($urandom_range(1, 1023)), IDX_W'($urandom_range(1, 1023))};

        // synchronous reset first; the block then clears its store
        // with the request side stalled, which send_req simply waits out
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // ---- directed part, no idling on either side ----
        write_limit(11'd0);
        send_req(REQ_SCAN, 4'd0, 10'd0);           // limit zero answers none
        drain(SETTLE_CYCLES);
        write_limit(11'd1024);
        send_req(REQ_SCAN, 4'd0, 10'd0);           // empty bitmap answers none
        send_req(REQ_SET, 4'd0, 10'd0);
        send_req(REQ_SCAN, 4'd0, 10'd0);           // lowest index
        send_req(REQ_SET, 4'd15, 10'd1023);
        send_req(REQ_SCAN, 4'd15, 10'd0);          // walks all 16 words
        send_req(REQ_SCAN, 4'd15, 10'd1023);       // start on the top bit
        send_req(REQ_UNUSED, 4'd15, 10'd1023);     // spare code, no effect
        send_req(REQ_CLEAR, 4'd0, 10'd0);
        send_req(REQ_SCAN, 4'd0, 10'd0);           // cleared again, none
        send_req(REQ_SET, 4'd5, 10'd63);
        send_req(REQ_SET, 4'd5, 10'd64);
        send_req(REQ_SCAN, 4'd5, 10'd64);          // word boundary
        send_req(REQ_SCAN, 4'd5, 10'd10);          // found in the start word
        send_req(REQ_CLEAR, 4'd5, 10'd64);
        send_req(REQ_SCAN, 4'd5, 10'd64);          // none after a clear
        drain(SETTLE_CYCLES);
        write_limit(11'd100);
        send_req(REQ_SET, 4'd7, 10'd120);
        send_req(REQ_SCAN, 4'd7, 10'd0);           // tail past the limit is not masked
        send_req(REQ_SCAN, 4'd7, 10'd100);         // start at the limit, none
        send_req(REQ_SCAN, 4'd7, 10'd99);          // start just below the limit
        drain(SETTLE_CYCLES);
        write_limit(11'd2047);                      // oversized limit acts as full size
        send_req(REQ_SCAN, 4'd15, 10'd1000);
        send_req(REQ_SCAN, 4'd5, 10'd0);

        // ---- random part: three idle modes, two limits each ----
        for (int mode = 0; mode < 3; mode++) begin
            for (int half = 0; half < 2; half++) begin
                drain(SETTLE_CYCLES);
                case (mode)
                    0: begin
                        send_gap_pct   = 24;
                        recv_stall_pct = 65;
                    end
                    1: begin
                        send_gap_pct   = 65;
                        recv_stall_pct = 24;
                    end
                    default: begin
                        send_gap_pct   = 0;
                        recv_stall_pct = 0;
                    end
                endcase
                write_limit(limit_plan[mode * 2 + half]);
                sent = 0;
                while (sent < ITEMS_PER_PHASE) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 35) begin
                        kind = REQ_SET;
                    end else if (roll < 55) begin
                        kind = REQ_CLEAR;
                    end else if (roll < 95) begin
                        kind = REQ_SCAN;
                    end else begin
                        kind = REQ_UNUSED;
                    end
                    // most traffic on a few bitmaps so scans meet real content
                    if ($urandom_range(0, 99) < 70) begin
                        sel = SEL_W'($urandom_range(0, 3));
                    end else begin
                        sel = SEL_W'($urandom_range(0, 15));
                    end
                    // positions: mostly below the limit, some in the word that
                    // holds the last entity (tail bits), the rest anywhere
                    roll = $urandom_range(0, 99);
                    if (roll < 60) begin
                        pos = POS_W'($urandom_range(0, limit_eff - 1));
                    end else if (roll < 75) begin
                        pos = POS_W'(((limit_eff - 1) / WORD_SPAN) * WORD_SPAN
                                     + $urandom_range(0, WORD_SPAN - 1));
                    end else begin
                        pos = POS_W'($urandom_range(0, MAX_ENTRIES - 1));
                    end
                    send_req(kind, sel, pos);
                    if (kind != REQ_UNUSED) begin
                        sent++;
                    end
                end
            end
        end

        drain(END_CYCLES);
        if (fail_count == 0 && n_pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ bitmap_find_next_set.f @@
design/bfns_pkg.sv
design/bfns_ram.sv
design/bfns_tzc.sv
design/bitmap_find_next_set.sv
tb/bfns_checker.sv
tb/tb.sv
